// ===== sv/bfa_pkg.sv =====
// Package for the best-fit block allocator: request and response structs,
// status codes, the command code type and the back-end state type. No dependencies.
`default_nettype none
package bfa_pkg;

   typedef enum logic [0:0] {
      CMD_ADD   = 1'b0,
      CMD_ALLOC = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ALLOCATED = 3'd0,
      ST_NO_FIT    = 3'd1,
      ST_ADDED     = 3'd2,
      ST_FULL      = 3'd3,
      ST_NO_SPLIT  = 3'd4
   } status_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] req_size;
      logic        batch_end;
   } req_type_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] granted_block;
      logic       batch_done;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_SCAN_LAST,
      BK_DECIDE,
      BK_SHIFT,
      BK_SHIFT_LAST,
      BK_INSERT
   } back_state_type;

endpackage
`default_nettype wire

// ===== sv/bfa_front.sv =====
// Front end of the allocator: takes request transfers and holds them in a
// two-entry queue for the back end. Depends on bfa_pkg.
`default_nettype none
module bfa_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bfa_pkg::req_type_type req_item,
   output logic                       q_valid,
   output bfa_pkg::req_type_type      q_item,
   input  wire logic                  q_pop
);

   bfa_pkg::req_type_type slot_ff [2];
   bfa_pkg::req_type_type slot_in [2];
   logic [1:0]            count_ff, count_in;
   logic                  push;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[0];

   // Queue shifts toward slot 0 on a pop.
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (q_pop && q_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot_in[0] = req_item;
         end else begin
            slot_in[1] = req_item;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bfa_back.sv =====
// Back end of the allocator: block table memory, best-fit scan, split and
// shift of the table. Depends on bfa_pkg.
`default_nettype none
module bfa_back #(
   parameter int MAX_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire bfa_pkg::req_type_type q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output bfa_pkg::rsp_type           rsp_item
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   // Entry: size, free mark, 6-bit number.
   typedef struct packed {
      logic [SIZE_BITS-1:0] size;
      logic                 free;
      logic [5:0]           number;
   } entry_type;

   entry_type mem [MAX_BLOCKS];
   entry_type rd_ff;

   bfa_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [5:0]           next_ff, next_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        best_ff, best_in;
   logic                 found_ff, found_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;
   logic [5:0]           best_num_ff, best_num_in;
   bfa_pkg::req_type_type cur_ff, cur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bfa_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 we;
   logic [IW-1:0]        waddr, raddr;
   entry_type            wdata;
   logic [SIZE_BITS-1:0] req_sz;
   logic                 hit;

   assign req_sz    = cur_ff.req_size[SIZE_BITS-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign hit = rd_ff.free && (rd_ff.size >= req_sz) &&
                (!found_ff || rd_ff.size < best_size_ff);

   // Table memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      best_size_in = best_size_ff;
      best_num_in  = best_num_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = idx_ff;
      wdata        = rd_ff;
      raddr        = idx_ff;
      unique case (state_ff)
         bfa_pkg::BK_IDLE: begin
            raddr = '0;
            if (q_valid) begin
               q_pop              = 1'b1;
               cur_in             = q_item;
               rsp_in.batch_done  = q_item.batch_end;
               idx_in             = '0;
               found_in           = 1'b0;
               if (q_item.req_type == bfa_pkg::CMD_ADD) begin
                  // Append a free block at the end of the table.
                  if (count_ff >= CW'(MAX_BLOCKS)) begin
                     rsp_in.status        = bfa_pkg::ST_FULL;
                     rsp_in.granted_block = '0;
                  end else begin
                     we           = 1'b1;
                     waddr        = count_ff[IW-1:0];
                     wdata.size   = q_item.req_size[SIZE_BITS-1:0];
                     wdata.free   = 1'b1;
                     wdata.number = next_ff;
                     rsp_in.status        = bfa_pkg::ST_ADDED;
                     rsp_in.granted_block = next_ff;
                     next_in  = next_ff + 6'd1;
                     count_in = count_ff + CW'(1);
                  end
                  rsp_valid_in = 1'b1;
               end else if (count_ff == '0) begin
                  rsp_in.status        = bfa_pkg::ST_NO_FIT;
                  rsp_in.granted_block = '0;
                  rsp_valid_in         = 1'b1;
               end else if (count_ff == CW'(1)) begin
                  state_in = bfa_pkg::BK_SCAN_LAST;
               end else begin
                  idx_in   = IW'(1);
                  state_in = bfa_pkg::BK_SCAN;
               end
            end
         end
         bfa_pkg::BK_SCAN, bfa_pkg::BK_SCAN_LAST: begin
            // rd_ff holds entry idx_ff-1 (or count-1 on the last); compare it.
            if (hit) begin
               found_in     = 1'b1;
               best_size_in = rd_ff.size;
               best_num_in  = rd_ff.number;
               best_in      = (state_ff == bfa_pkg::BK_SCAN_LAST) ?
                              IW'(count_ff - CW'(1)) : idx_ff - IW'(1);
            end
            if (state_ff == bfa_pkg::BK_SCAN_LAST) begin
               state_in = bfa_pkg::BK_DECIDE;
            end else if ({1'b0, idx_ff} == CW'(count_ff - CW'(1))) begin
               state_in = bfa_pkg::BK_SCAN_LAST;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         bfa_pkg::BK_DECIDE: begin
            rsp_valid_in = 1'b1;
            if (!found_ff) begin
               rsp_in.status        = bfa_pkg::ST_NO_FIT;
               rsp_in.granted_block = '0;
               state_in             = bfa_pkg::BK_IDLE;
            end else begin
               rsp_in.granted_block = best_num_ff;
               we           = 1'b1;
               waddr        = best_ff;
               wdata.free   = 1'b0;
               wdata.number = best_num_ff;
               wdata.size   = best_size_ff;
               state_in     = bfa_pkg::BK_IDLE;
               if (best_size_ff <= req_sz) begin
                  rsp_in.status = bfa_pkg::ST_ALLOCATED;
               end else if (count_ff >= CW'(MAX_BLOCKS)) begin
                  rsp_in.status = bfa_pkg::ST_NO_SPLIT;
               end else begin
                  rsp_in.status = bfa_pkg::ST_ALLOCATED;
                  wdata.size    = req_sz;
                  // Shift entries best+1..count-1 up by one, top first.
                  idx_in = IW'(count_ff - CW'(1));
                  raddr  = IW'(count_ff - CW'(1));
                  if ({1'b0, best_ff} == CW'(count_ff - CW'(1))) begin
                     state_in = bfa_pkg::BK_INSERT;
                  end else begin
                     state_in = bfa_pkg::BK_SHIFT;
                  end
               end
            end
         end
         bfa_pkg::BK_SHIFT: begin
            // Read issued last cycle; write it one place up next cycle.
            raddr    = idx_ff;
            state_in = bfa_pkg::BK_SHIFT_LAST;
         end
         bfa_pkg::BK_SHIFT_LAST: begin
            we    = 1'b1;
            waddr = idx_ff + IW'(1);
            wdata = rd_ff;
            if (idx_ff == best_ff + IW'(1)) begin
               state_in = bfa_pkg::BK_INSERT;
            end else begin
               idx_in   = idx_ff - IW'(1);
               raddr    = idx_ff - IW'(1);
               state_in = bfa_pkg::BK_SHIFT_LAST;
            end
         end
         bfa_pkg::BK_INSERT: begin
            we           = 1'b1;
            waddr        = best_ff + IW'(1);
            wdata.size   = best_size_ff - req_sz;
            wdata.free   = 1'b1;
            wdata.number = next_ff;
            next_in      = next_ff + 6'd1;
            count_in     = count_ff + CW'(1);
            state_in     = bfa_pkg::BK_IDLE;
         end
         default: begin
            state_in = bfa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_size_ff <= best_size_in;
      best_num_ff  <= best_num_in;
      cur_ff       <= cur_in;
      rsp_ff       <= rsp_in;
      found_ff     <= found_in;
      if (reset) begin
         state_ff     <= bfa_pkg::BK_IDLE;
         count_ff     <= '0;
         next_ff      <= 6'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator: front queue and back end.
// Depends on bfa_pkg, bfa_front and bfa_back.
//
// Usage: a request transfer happens at a rising edge with start high and
// busy low; req_item carries type (add/allocate), size and batch_end.
// Each request gives exactly one response on rsp_item, shown for one cycle
// with rsp_valid high; the receiver cannot stall it.
// An add, or an allocate on an empty table, passes through the queue slot
// and the response register. Any other allocate reads the table through the
// single memory port, one entry a cycle, then decides; on a split it then
// shifts later entries up and inserts the remainder (only inserts when the
// chosen block is the last entry) before the next request starts.
// A two-entry queue holds requests while the back end works; busy is high
// while it is full.
// Reset clears the entry count, sets the next block number to one and
// empties the queue; the table contents need no clearing.
`default_nettype none
module best_fit_block_allocator #(
   parameter int MAX_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bfa_pkg::req_type_type req_item,
   output logic                       rsp_valid,
   output bfa_pkg::rsp_type           rsp_item
);

   logic                  q_valid, q_pop;
   bfa_pkg::req_type_type q_item;

   bfa_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   bfa_back #(.MAX_BLOCKS(MAX_BLOCKS), .SIZE_BITS(SIZE_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

endmodule
`default_nettype wire

// ===== verif/best_fit_block_allocator_tb.sv =====
// Self-checking testbench for the best-fit block allocator: drives add and
// allocate requests, predicts each response from a behavioral table model.
// Depends on bfa_pkg and best_fit_block_allocator.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_block_allocator_tb;

   localparam int TABLE_DEPTH = 32;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   bfa_pkg::req_type_type req_item = '0;
   logic                  rsp_valid;
   bfa_pkg::rsp_type      rsp_item;

   // Predicted block table.
   logic [15:0] tbl_size [TABLE_DEPTH];
   logic        tbl_free [TABLE_DEPTH];
   logic [5:0]  tbl_num  [TABLE_DEPTH];
   int          tbl_count;
   int          num_next;

   bfa_pkg::rsp_type pending_rsp[$];
   int               error_count = 0;

   best_fit_block_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Compute the response to one request and update the table.
   function automatic bfa_pkg::rsp_type allocate_predict(input bfa_pkg::req_type_type rq);
      bfa_pkg::rsp_type r;
      int               best;
      bit               found;
      r.batch_done = rq.batch_end;
      r.granted_block = '0;
      if (rq.req_type == bfa_pkg::CMD_ADD) begin
         if (tbl_count >= TABLE_DEPTH) begin
            r.status = bfa_pkg::ST_FULL;
         end else begin
            tbl_size[tbl_count] = rq.req_size;
            tbl_free[tbl_count] = 1'b1;
            tbl_num[tbl_count] = 6'(num_next);
            r.granted_block = 6'(num_next);
            r.status = bfa_pkg::ST_ADDED;
            num_next++;
            tbl_count++;
         end
         return r;
      end
      found = 0;
      best = 0;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_free[i] && tbl_size[i] >= rq.req_size &&
             (!found || tbl_size[i] < tbl_size[best])) begin
            best = i;
            found = 1;
         end
      end
      if (!found) begin
         r.status = bfa_pkg::ST_NO_FIT;
         return r;
      end
      tbl_free[best] = 1'b0;
      r.granted_block = tbl_num[best];
      r.status = bfa_pkg::ST_ALLOCATED;
      if (tbl_size[best] <= rq.req_size) return r;
      if (tbl_count >= TABLE_DEPTH) begin
         r.status = bfa_pkg::ST_NO_SPLIT;
         return r;
      end
      // Open a slot after the chosen block for the remainder.
      for (int i = tbl_count; i > best + 1; i--) begin
         tbl_size[i] = tbl_size[i-1];
         tbl_free[i] = tbl_free[i-1];
         tbl_num[i] = tbl_num[i-1];
      end
      tbl_size[best+1] = tbl_size[best] - rq.req_size;
      tbl_free[best+1] = 1'b1;
      tbl_num[best+1] = 6'(num_next);
      num_next++;
      tbl_count++;
      tbl_size[best] = rq.req_size;
      return r;
   endfunction

   // Random gap: half the time none, else mostly short, sometimes long.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 9);
      if (n < 5) n = 0;
      else if (n < 9) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      repeat (n) @(negedge clock);
   endtask

   // Send one request; start stays high until the transfer. Start and the
   // payload are set at the falling edge, so back-to-back calls may touch
   // start twice in one time step.
   task automatic send_request(input bfa_pkg::cmd_type kind, input logic [15:0] size,
                               input logic last);
      bfa_pkg::req_type_type rq;
      rq.req_type = kind;
      rq.req_size = size;
      rq.batch_end = last;
      start = 1'b1;
      req_item = rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(allocate_predict(rq));
      @(negedge clock);
      start = 1'b0;
      idle_gap();
   endtask

   task automatic drain_responses();
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      bfa_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_item.status, want.status));
            if (rsp_item.granted_block !== want.granted_block)
               report_mismatch($sformatf("block %0d, expected %0d",
                                         rsp_item.granted_block, want.granted_block));
            if (rsp_item.batch_done !== want.batch_done)
               report_mismatch("batch_done mismatch");
         end
      end
   end

   // Directed: edge sizes, exact fit, no fit, split, zero size.
   task automatic test_directed();
      send_request(bfa_pkg::CMD_ALLOC, 16'd5, 1'b1);
      send_request(bfa_pkg::CMD_ADD, 16'hFFFF, 1'b0);
      send_request(bfa_pkg::CMD_ADD, 16'd0, 1'b1);
      send_request(bfa_pkg::CMD_ADD, 16'd100, 1'b0);
      send_request(bfa_pkg::CMD_ADD, 16'd100, 1'b0);
      send_request(bfa_pkg::CMD_ALLOC, 16'd0, 1'b0);
      send_request(bfa_pkg::CMD_ALLOC, 16'd100, 1'b0);
      send_request(bfa_pkg::CMD_ALLOC, 16'd40, 1'b0);
      send_request(bfa_pkg::CMD_ALLOC, 16'hFFFF, 1'b1);
      send_request(bfa_pkg::CMD_ALLOC, 16'hFFFF, 1'b0);
      send_request(bfa_pkg::CMD_ALLOC, 16'd1, 1'b1);
   endtask

   // Fill the table, then show add rejection and unsplit grants.
   task automatic test_full_table();
      while (tbl_count < TABLE_DEPTH)
         send_request(bfa_pkg::CMD_ADD, 16'($urandom_range(50, 65535)),
                      1'($urandom_range(0, 1)));
      send_request(bfa_pkg::CMD_ADD, 16'd7, 1'b1);
      send_request(bfa_pkg::CMD_ALLOC, 16'd10, 1'b0);
      send_request(bfa_pkg::CMD_ALLOC, 16'd0, 1'b1);
      // Hold off until everything has answered.
      drain_responses();
   endtask

   // Random traffic on the full table: rejected adds, full scans and
   // grants of whatever free blocks remain; allocs dominate.
   task automatic test_random(input int items);
      int          sel;
      logic [15:0] sz;
      for (int k = 0; k < items; k++) begin
         sel = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: sz = 16'($urandom);
            1: sz = 16'($urandom_range(0, 15));
            2: sz = 16'($urandom_range(0, 1023));
            default: sz = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
         endcase
         if (sel < 35) send_request(bfa_pkg::CMD_ADD, sz, 1'($urandom_range(0, 1)));
         else send_request(bfa_pkg::CMD_ALLOC, sz, 1'($urandom_range(0, 1)));
         if (sel == 99) drain_responses();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      tbl_count = 0;
      num_next = 1;
      test_directed();
      test_full_table();
      test_random(1000);
      drain_responses();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("best_fit_block_allocator regression: pass");
      end else begin
         $display("best_fit_block_allocator regression: fail");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("best_fit_block_allocator regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
